[hdl/pwrc_pkg.sv]
// Shared constants, types and helpers of the pixel write run coalescer.
package pwrc_pkg;

    localparam int RUN_PIXELS = 32;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = (RUN_PIXELS > 1) ? $clog2(RUN_PIXELS) : 1;
    localparam int CNT_W      = $clog2(RUN_PIXELS + 1);
    localparam int BADDR_W    = ADDR_W + 1;
    localparam int MEM_DEPTH  = 2 << ADDR_W;
    localparam int POS_W      = 2 * COORD_W + 4;
    localparam int BYTE_W     = 8;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Full run handed from the front to the back
    typedef struct packed {
        logic               bank;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [CNT_W-1:0]   count;
    } t_flush;

    // Pixel store write port
    typedef struct packed {
        logic               en;
        logic [BADDR_W-1:0] addr;
        logic [COLOR_W-1:0] data;
    } t_store_wr;

    // Bank released by the back
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // Exchange high and low bytes of a colour
    function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = c[BYTE_W-1:0] & 8'hff;
        hi = c[COLOR_W-1:BYTE_W] & 8'hff;
        return {lo, hi};
    endfunction

endpackage

[hdl/pwrc_ifs.sv]
// Channel interfaces: pixel input, burst output and configuration write.
interface pwrc_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [pwrc_pkg::COORD_W-1:0] x;
    logic [pwrc_pkg::COORD_W-1:0] y;
    logic [pwrc_pkg::COLOR_W-1:0] color;

    modport source (output valid, mode, x, y, color, input ready);
    modport sink   (input valid, mode, x, y, color, output ready);
endinterface

interface pwrc_burst_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [pwrc_pkg::COORD_W-1:0] win_left;
    logic [pwrc_pkg::COORD_W-1:0] win_top;
    logic [pwrc_pkg::COORD_W-1:0] win_right;
    logic [pwrc_pkg::COORD_W-1:0] win_bottom;
    logic [pwrc_pkg::COLOR_W-1:0] pixel;
    logic                         last;

    modport source (output valid, kind, win_left, win_top, win_right, win_bottom, pixel,
                    last, input ready);
    modport sink   (input valid, kind, win_left, win_top, win_right, win_bottom, pixel,
                    last, output ready);
endinterface

interface pwrc_cfg_if;
    logic valid;
    logic ready;
    logic byte_swap;

    modport source (output valid, byte_swap, input ready);
    modport sink   (input valid, byte_swap, output ready);
endinterface

[hdl/pwrc_queue.sv]
// Two-entry queue of flushed runs between the front and the back.
module pwrc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pwrc_pkg::t_flush i_push_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_avail,
    output pwrc_pkg::t_flush o_head
);
    import pwrc_pkg::*;

    t_flush     r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_space = (r_fill != 2'd2);
    assign o_avail = (r_fill != 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

[hdl/pwrc_front.sv]
// Front part: takes pixel words, tracks box and count, fills store banks, posts flushes.
module pwrc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pwrc_pix_if.sink            i_pix,
    pwrc_cfg_if.sink            i_cfg,
    input  logic                i_q_space,
    output logic                o_q_push,
    output pwrc_pkg::t_flush    o_q_data,
    output pwrc_pkg::t_store_wr o_store_wr,
    input  pwrc_pkg::t_release  i_release
);
    import pwrc_pkg::*;

    logic               r_swap;
    logic               r_bank;
    logic [1:0]         r_busy;
    logic [CNT_W-1:0]   r_count;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_top;
    logic [COORD_W-1:0] r_right;
    logic [COORD_W-1:0] r_bottom;

    logic               n_bank;
    logic [1:0]         n_busy;
    logic [CNT_W-1:0]   n_count;

    logic               is_write;
    logic               is_flush;
    logic [COORD_W-1:0] grow_r;
    logic [COORD_W-1:0] grow_b;
    logic signed [COORD_W:0]   dy;
    logic signed [COORD_W:0]   dx;
    logic [COORD_W:0]          span;
    logic signed [POS_W-1:0]   pos;
    logic               mismatch;
    logic               fresh;
    logic               store_bank;
    logic [CNT_W-1:0]   base;
    logic [CNT_W-1:0]   filled;
    logic               full;
    logic               accept;
    logic [COORD_W-1:0] nb_left;
    logic [COORD_W-1:0] nb_top;
    logic [COORD_W-1:0] nb_right;
    logic [COORD_W-1:0] nb_bottom;
    logic               set_busy;
    logic               set_bank;

    assign i_cfg.ready = 1'b1;

    // Classify the offered word and work out its place in the box
    always_comb begin
        is_write = (i_pix.mode == MODE_WRITE);
        is_flush = (i_pix.mode == MODE_FLUSH);
        grow_r   = (i_pix.x > r_right)  ? i_pix.x : r_right;
        grow_b   = (i_pix.y > r_bottom) ? i_pix.y : r_bottom;
        dy       = $signed({1'b0, i_pix.y}) - $signed({1'b0, r_top});
        dx       = $signed({1'b0, i_pix.x}) - $signed({1'b0, r_left});
        span     = {1'b0, grow_r} - {1'b0, r_left} + {{COORD_W{1'b0}}, 1'b1};
        pos      = POS_W'(dy * $signed({1'b0, span})) + POS_W'(dx);
        mismatch = is_write && (r_count != '0)
                   && (pos != $signed({{(POS_W-CNT_W){1'b0}}, r_count}));
        fresh      = mismatch || (r_count == '0);
        store_bank = mismatch ? ~r_bank : r_bank;
        base       = fresh ? '0 : r_count;
        filled     = base + CNT_W'(1);
        full       = (filled == CNT_W'(RUN_PIXELS));
        if (fresh) begin
            nb_left   = i_pix.x;
            nb_top    = i_pix.y;
            nb_right  = i_pix.x;
            nb_bottom = i_pix.y;
        end else begin
            nb_left   = r_left;
            nb_top    = r_top;
            nb_right  = grow_r;
            nb_bottom = grow_b;
        end
    end

    // Hold the word while the target bank drains or the queue is full
    assign i_pix.ready = i_q_space && (is_flush || !r_busy[store_bank]);
    assign accept      = i_pix.valid && i_pix.ready;

    // Post flushes and store writes
    always_comb begin
        o_q_push = 1'b0;
        o_q_data = '{bank: r_bank, left: r_left, top: r_top, right: r_right,
                     bottom: r_bottom, count: r_count};
        set_busy = 1'b0;
        set_bank = r_bank;
        n_bank   = r_bank;
        n_count  = r_count;
        if (accept) begin
            if (is_flush) begin
                if (r_count != '0) begin
                    o_q_push = 1'b1;
                    set_busy = 1'b1;
                    n_bank   = ~r_bank;
                    n_count  = '0;
                end
            end else if (full) begin
                o_q_push = 1'b1;
                o_q_data = '{bank: store_bank, left: nb_left, top: nb_top, right: nb_right,
                             bottom: nb_bottom, count: filled};
                set_busy = 1'b1;
                set_bank = store_bank;
                n_bank   = ~store_bank;
                n_count  = '0;
            end else begin
                if (mismatch) begin
                    o_q_push = 1'b1;
                    set_busy = 1'b1;
                end
                n_bank  = store_bank;
                n_count = filled;
            end
        end
        o_store_wr.en   = accept && is_write;
        o_store_wr.addr = {store_bank, base[ADDR_W-1:0]};
        o_store_wr.data = r_swap ? swap_bytes(i_pix.color) : i_pix.color;
    end

    // Track banks owned by the back
    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[set_bank] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap  <= 1'b1;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
            r_count <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_swap <= i_cfg.byte_swap;
            end
            r_bank  <= n_bank;
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    // Box registers; only read while a run is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else if (accept && is_write) begin
            r_left   <= nb_left;
            r_top    <= nb_top;
            r_right  <= nb_right;
            r_bottom <= nb_bottom;
        end
    end

endmodule

[hdl/pwrc_back.sv]
// Back part: holds the pixel store and plays each flushed run out as header plus words.
module pwrc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwrc_pkg::t_store_wr i_store_wr,
    input  logic                i_q_avail,
    input  pwrc_pkg::t_flush    i_q_head,
    output logic                o_q_pop,
    output pwrc_pkg::t_release  o_release,
    pwrc_burst_if.source        o_burst
);
    import pwrc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DATA = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [COLOR_W-1:0]  r_mem [MEM_DEPTH];
    logic [COLOR_W-1:0]  r_rd_data;
    logic                r_bank;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_idx;

    logic                r_ovalid;
    logic                r_okind;
    logic [COORD_W-1:0]  r_oleft;
    logic [COORD_W-1:0]  r_otop;
    logic [COORD_W-1:0]  r_oright;
    logic [COORD_W-1:0]  r_obottom;
    logic [COLOR_W-1:0]  r_opixel;
    logic                r_olast;

    logic                out_free;
    logic                start;
    logic                step;
    logic                end_run;
    logic                rd_en;
    logic [BADDR_W-1:0]  rd_addr;

    assign out_free = !r_ovalid || o_burst.ready;

    // Sequence header and words
    always_comb begin
        n_state = r_state;
        start   = 1'b0;
        step    = 1'b0;
        end_run = 1'b0;
        rd_en   = 1'b0;
        rd_addr = {i_q_head.bank, {ADDR_W{1'b0}}};
        case (r_state)
            S_IDLE: begin
                if (i_q_avail && out_free) begin
                    start   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (out_free) begin
                    step = 1'b1;
                    if ({1'b0, r_idx} == CNT_W'(r_cnt - CNT_W'(1))) begin
                        end_run = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {r_bank, r_idx + ADDR_W'(1)};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_q_pop         = start;
    assign o_release.valid = end_run;
    assign o_release.bank  = r_bank;

    // Pixel store: written by the front, read here
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_mem[i_store_wr.addr] <= i_store_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (start) begin
            r_bank <= i_q_head.bank;
            r_cnt  <= i_q_head.count;
            r_idx  <= '0;
        end else if (step && !end_run) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (start || step) begin
            r_ovalid <= 1'b1;
        end else if (o_burst.ready) begin
            r_ovalid <= 1'b0;
        end
        if (start) begin
            r_okind   <= KIND_HEADER;
            r_oleft   <= i_q_head.left;
            r_otop    <= i_q_head.top;
            r_oright  <= i_q_head.right;
            r_obottom <= i_q_head.bottom;
            r_opixel  <= '0;
            r_olast   <= 1'b0;
        end else if (step) begin
            r_okind   <= KIND_DATA;
            r_oleft   <= '0;
            r_otop    <= '0;
            r_oright  <= '0;
            r_obottom <= '0;
            r_opixel  <= r_rd_data;
            r_olast   <= end_run;
        end
    end

    assign o_burst.valid      = r_ovalid;
    assign o_burst.kind       = r_okind;
    assign o_burst.win_left   = r_oleft;
    assign o_burst.win_top    = r_otop;
    assign o_burst.win_right  = r_oright;
    assign o_burst.win_bottom = r_obottom;
    assign o_burst.pixel      = r_opixel;
    assign o_burst.last       = r_olast;

endmodule

[hdl/pixel_write_run_coalescer.sv]
// Top level of the pixel write run coalescer: front, run queue and back.
//
//   channel   dir   handshake      word
//   i_pix     in    valid/ready    mode, x, y, color
//   o_burst   out   valid/ready    kind, win_left..win_bottom, pixel, last
//   i_cfg     in    valid/ready    byte_swap (always ready)
//
// The front takes one pixel word per cycle while its store bank is free and the queue
// has space; the back plays a run of N pixels out as N+1 words, one per cycle while
// o_burst is ready. Two store banks let the back drain one run while the front fills
// the other; the front holds i_pix when the bank it must write is still draining.
// Reset (synchronous, active low) empties the queue and run; byte_swap returns to 1.
// The store needs no clearing pass: every word read was written in its run.
module pixel_write_run_coalescer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwrc_pix_if.sink      i_pix,
    pwrc_cfg_if.sink      i_cfg,
    pwrc_burst_if.source  o_burst
);
    import pwrc_pkg::*;

    logic      q_space;
    logic      q_push;
    t_flush    q_in;
    logic      q_pop;
    logic      q_avail;
    t_flush    q_head;
    t_store_wr store_wr;
    t_release  release_bank;

    // Accept and classify pixel words
    pwrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg      (i_cfg),
        .i_q_space  (q_space),
        .o_q_push   (q_push),
        .o_q_data   (q_in),
        .o_store_wr (store_wr),
        .i_release  (release_bank)
    );

    // Queue flushed runs
    pwrc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_space     (q_space),
        .i_pop       (q_pop),
        .o_avail     (q_avail),
        .o_head      (q_head)
    );

    // Drain runs to the output
    pwrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_store_wr (store_wr),
        .i_q_avail  (q_avail),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .o_release  (release_bank),
        .o_burst    (o_burst)
    );

endmodule

[tb/pixel_write_run_coalescer_tb.sv]
// Self-checking testbench for the pixel write run coalescer: run gathering, flushes, byte swap.
module pixel_write_run_coalescer_tb;

    import pwrc_pkg::*;

    localparam int IDLE_MAX     = 18;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 40;

    // One burst word as the display side sees it
    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] pixel;
        logic               last;
    } t_burst_word;

    logic i_clk;
    logic i_rst_n;

    pwrc_pix_if   pix ();
    pwrc_cfg_if   cfg ();
    pwrc_burst_if burst ();

    logic sink_rdy;
    logic sink_hold;
    bit   idle_on = 1'b1;
    bit   hold_go = 1'b0;
    int   err_cnt = 0;
    int   words_seen = 0;

    // Burst words still owed by the block, oldest first
    t_burst_word words_due [$];
    t_burst_word step_words [$];

    // Own copy of the run store, bounding box and byte swap setting
    logic [COLOR_W-1:0] run_mem [RUN_PIXELS];
    int   held_n = 0;
    int   box_l = 0;
    int   box_t = 0;
    int   box_r = 0;
    int   box_b = 0;
    logic swap_en = 1'b1;

    assign burst.ready = sink_rdy & ~sink_hold;

    pixel_write_run_coalescer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_burst (burst)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall bursts while idling is on
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                sink_rdy <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX)) @(posedge i_clk);
            end else begin
                sink_rdy <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Receiver: one long hold-off once requested
    initial begin
        sink_hold <= 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    task automatic note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("word %0d field %s: got %h, want %h",
                                    words_seen, name, got, want));
    endtask

    // Emit the held run as a window header plus its pixels, then clear it
    task automatic flush_held_run();
        t_burst_word w;
        if (held_n == 0)
            return;
        w        = '0;
        w.kind   = KIND_HEADER;
        w.left   = box_l[COORD_W-1:0];
        w.top    = box_t[COORD_W-1:0];
        w.right  = box_r[COORD_W-1:0];
        w.bottom = box_b[COORD_W-1:0];
        step_words.push_back(w);
        for (int i = 0; i < held_n && i < RUN_PIXELS; i++) begin
            w       = '0;
            w.kind  = KIND_DATA;
            w.pixel = run_mem[i];
            step_words.push_back(w);
        end
        held_n = 0;
        box_l  = 0;
        box_t  = 0;
        box_r  = 0;
        box_b  = 0;
    endtask

    // Work out the burst words one accepted input word causes
    task automatic coalesce_pixel(logic mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COLOR_W-1:0] color);
        logic [COLOR_W-1:0] stored;
        int          xi, yi, nl, nt, nr, nb, pos;
        t_burst_word w;
        step_words.delete();
        if (mode == MODE_FLUSH) begin
            flush_held_run();
        end else begin
            xi     = x;
            yi     = y;
            stored = swap_en ? {color[7:0], color[15:8]} : color;
            if (held_n == 0) begin
                nl  = xi;
                nt  = yi;
                nr  = xi;
                nb  = yi;
                pos = 0;
            end else begin
                nl  = box_l;
                nt  = box_t;
                nr  = (xi > box_r) ? xi : box_r;
                nb  = (yi > box_b) ? yi : box_b;
                pos = (yi - nt) * (nr - nl + 1) + (xi - nl);
            end
            // Off-sequence pixel: drain the run and restart at this pixel
            if (pos != held_n) begin
                flush_held_run();
                pos = 0;
                nl  = xi;
                nt  = yi;
                nr  = xi;
                nb  = yi;
            end
            if (pos >= 0 && pos < RUN_PIXELS)
                run_mem[pos] = stored;
            held_n++;
            box_l = nl;
            box_t = nt;
            box_r = nr;
            box_b = nb;
            if (held_n >= RUN_PIXELS)
                flush_held_run();
        end
        foreach (step_words[i]) begin
            w      = step_words[i];
            w.last = (i == step_words.size() - 1);
            words_due.push_back(w);
        end
    endtask

    // Check each word the display side takes against the oldest one owed
    always @(posedge i_clk) begin : burst_check
        t_burst_word want;
        if (i_rst_n && burst.valid && burst.ready) begin
            if (words_due.size() == 0) begin
                note_mismatch($sformatf("word %0d not owed: kind=%0d pixel=%h last=%0d",
                                        words_seen, burst.kind, burst.pixel, burst.last));
            end else begin
                want = words_due.pop_front();
                check_field("kind",       burst.kind,       want.kind);
                check_field("win_left",   burst.win_left,   want.left);
                check_field("win_top",    burst.win_top,    want.top);
                check_field("win_right",  burst.win_right,  want.right);
                check_field("win_bottom", burst.win_bottom, want.bottom);
                check_field("pixel",      burst.pixel,      want.pixel);
                check_field("last",       burst.last,       want.last);
            end
            words_seen++;
        end
    end

    // Offer one input word, hold it until taken, then predict
    task automatic send_word(logic mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COLOR_W-1:0] color);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.mode  <= mode;
        pix.x     <= x;
        pix.y     <= y;
        pix.color <= color;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        coalesce_pixel(mode, x, y, color);
    endtask

    task automatic send_pixel(int x, int y, int color);
        send_word(MODE_WRITE, x[COORD_W-1:0], y[COORD_W-1:0], color[COLOR_W-1:0]);
    endtask

    // Flush with random don't-care fields
    task automatic send_flush();
        send_word(MODE_FLUSH, COORD_W'($urandom), COORD_W'($urandom), COLOR_W'($urandom));
    endtask

    // Raster-order pixels in a box of width w; optionally skip one in the middle
    task automatic send_raster(int x0, int y0, int w, int len, bit broken);
        int k;
        for (int i = 0; i < len; i++) begin
            k = (broken && i >= len / 2) ? i + 1 : i;
            send_pixel(x0 + k % w, y0 + k / w, $urandom);
        end
    endtask

    // Drop valid and wait until every owed word has come out
    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_byte_swap(logic value);
        wait_drained();
        cfg.valid     <= 1'b1;
        cfg.byte_swap <= value;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        swap_en = value;
    endtask

    // Mostly well-formed raster runs, with flushes, broken runs and stray pixels
    task automatic send_random_traffic(int n_items);
        int sent, pick, w, len, rows, x0, y0;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                w    = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
                len  = $urandom_range(1, 40);
                rows = (len + w) / w;
                x0   = ($urandom_range(0, 7) == 0) ? 1024 - w : $urandom_range(0, 1024 - w);
                y0   = ($urandom_range(0, 7) == 0) ? 1024 - rows
                                                   : $urandom_range(0, 1024 - rows);
                send_raster(x0, y0, w, len, $urandom_range(0, 3) == 0);
                sent += len;
            end else if (pick < 8) begin
                if (held_n != 0)
                    sent++;
                send_flush();
            end else begin
                send_pixel($urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // Edge coordinates, empty flush, box growth, mismatches left, right and above
    task automatic test_directed();
        send_flush();
        send_pixel(0, 0, 16'h0000);
        send_flush();
        send_pixel(1023, 1023, 16'hFFFF);
        send_pixel(0, 0, 16'h00FF);
        send_flush();
        send_pixel(1021, 5, 16'h1234);
        send_pixel(1022, 5, 16'h5678);
        send_pixel(1023, 5, 16'h9ABC);
        send_pixel(1021, 6, 16'hDEF0);
        send_pixel(1022, 6, 16'h8001);
        // left of the box, yet its position happens to equal the held count
        send_pixel(1020, 7, 16'h7FFE);
        send_flush();
        send_pixel(10, 10, 16'hA5A5);
        send_pixel(12, 10, 16'h5A5A);
        send_pixel(12, 9, 16'h0F0F);
        send_flush();
    endtask

    // Runs that fill the store, in one row and as a block of rows
    task automatic test_full_run();
        write_byte_swap(1'b0);
        send_raster(1024 - RUN_PIXELS, 1023, RUN_PIXELS, RUN_PIXELS, 1'b0);
        send_raster(0, 0, 4, RUN_PIXELS + 1, 1'b0);
        send_flush();
    endtask

    task automatic test_random_mix();
        write_byte_swap(1'b1);
        send_random_traffic(25);
        write_byte_swap(1'b0);
        send_random_traffic(25);
    endtask

    // Hold the receiver off while a long raster run, one full run and more, keeps arriving
    task automatic test_backpressure();
        write_byte_swap(1'b1);
        hold_go = 1'b1;
        send_raster(300, 400, 10, 60, 1'b0);
        send_flush();
    endtask

    task automatic test_steady_stream();
        write_byte_swap(1'b0);
        idle_on = 1'b0;
        send_random_traffic(40);
        send_flush();
    endtask

    initial begin
        pix.valid     <= 1'b0;
        pix.mode      <= MODE_WRITE;
        pix.x         <= '0;
        pix.y         <= '0;
        pix.color     <= '0;
        cfg.valid     <= 1'b0;
        cfg.byte_swap <= 1'b1;
        i_rst_n       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_run();
        test_random_mix();
        test_backpressure();
        test_steady_stream();
        wait_drained();

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/pwrc_pkg.sv
hdl/pwrc_ifs.sv
hdl/pwrc_queue.sv
hdl/pwrc_front.sv
hdl/pwrc_back.sv
hdl/pixel_write_run_coalescer.sv
tb/pixel_write_run_coalescer_tb.sv
